### sv/mnlb_pkg.sv
`timescale 1ns / 1ps

package mnlb_pkg;

   // Field widths
   localparam int NUM_W  = 31;
   localparam int DOT_W  = 16;
   localparam int TICK_W = 18;

   // Digit store sizing
   localparam int MAX_DIGITS  = 10;
   localparam int DIGIT_W     = 4;
   localparam int CNT_W       = $clog2(MAX_DIGITS + 1);
   localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);

   // Conversion step counter
   localparam int STEP_W = $clog2(NUM_W);

   // Elements per digit
   localparam int ELEM_W = 3;
   localparam logic [ELEM_W-1:0] ELEM_LAST = 3'd4;

   // Register reset values
   localparam logic [DOT_W-1:0] DOT_TICKS_RESET    = 16'd100;
   localparam logic             ACTIVE_LEVEL_RESET = 1'b1;

   // Request operations
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // Register indexes
   localparam logic CSR_DOT_TICKS    = 1'b0;
   localparam logic CSR_ACTIVE_LEVEL = 1'b1;

   typedef enum logic [3:0] {
      PH_IDLE      = 4'b0001,
      PH_LIT       = 4'b0010,
      PH_ELEM_GAP  = 4'b0100,
      PH_DIGIT_GAP = 4'b1000
   } phase_type;

   typedef struct packed {
      logic capture;
      logic conv_init;
      logic conv_step;
      logic tick_apply;
      logic start_finish;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic phase_idle;
      logic conv_last;
      logic op_start;
   } sts_type;

endpackage

### sv/mnlb_ctrl.sv
`timescale 1ns / 1ps

module mnlb_ctrl import mnlb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic    req_operation,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    rsp_valid,
   input  logic    rsp_ready
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_EXEC = 4'b0010,
      S_CONV = 4'b0100,
      S_FIN  = 4'b1000
   } ctrl_state_type;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           accept;
   logic           out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               // a start only runs the conversion when nothing is being sent
               if (req_operation == OP_START && sts.phase_idle) begin
                  cmd.conv_init = 1'b1;
                  state_in      = S_CONV;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_EXEC: begin
            if (out_free) begin
               cmd.tick_apply = !sts.op_start;
               cmd.rsp_load   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_CONV: begin
            cmd.conv_step = 1'b1;
            if (sts.conv_last) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (out_free) begin
               cmd.start_finish = 1'b1;
               cmd.rsp_load     = 1'b1;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while still pending");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted request did not start work");

   a_conv_only_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.conv_init |-> sts.phase_idle)
      else $error("conversion started during a send");

endmodule

### sv/mnlb_dp.sv
`timescale 1ns / 1ps

module mnlb_dp import mnlb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output sts_type          sts,
   input  logic             req_operation,
   input  logic [NUM_W-1:0] req_number,
   input  logic             csr_write_enable,
   input  logic             csr_index,
   input  logic [DOT_W-1:0] csr_write_data,
   output logic             rsp_led_level,
   output logic             rsp_busy_res,
   output logic             rsp_finished
);

   function automatic logic elem_is_dot(input logic [DIGIT_W-1:0] d,
                                        input logic [ELEM_W-1:0] k);
      logic [DIGIT_W-1:0] kx;
      kx = {{(DIGIT_W-ELEM_W){1'b0}}, k};
      if (d <= 4'd5) begin
         return kx < d;
      end
      return kx >= (d - 4'd5);
   endfunction

   // configuration
   logic [DOT_W-1:0]       dot_ticks_ff;
   logic                   active_ff;

   // conversion
   logic                   op_ff;
   logic [NUM_W-1:0]       bin_ff, bin_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [DIGIT_W-1:0]     digit_ff [MAX_DIGITS];
   logic [DIGIT_W-1:0]     digit_in [MAX_DIGITS];
   logic [DIGIT_W-1:0]     adj      [MAX_DIGITS];

   // send state
   phase_type              phase_ff, phase_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       index_ff, index_in;
   logic [ELEM_W-1:0]      elem_ff, elem_in;
   logic [TICK_W-1:0]      tick_ff, tick_in;
   logic                   finished_in;

   // helpers
   logic [DOT_W-1:0]       dot;
   logic [TICK_W-1:0]      dot_x, dot3, cur_len, tick_inc;
   logic [CNT_W-1:0]       pos, index_nxt, found_cnt;
   logic [DIGIT_W-1:0]     cur_digit;

   assign dot      = (dot_ticks_ff == '0) ? DOT_W'(1) : dot_ticks_ff;
   assign dot_x    = {{(TICK_W-DOT_W){1'b0}}, dot};
   assign dot3     = dot_x + {dot_x[TICK_W-2:0], 1'b0};
   assign tick_inc = tick_ff + TICK_W'(1);
   assign pos      = count_ff - CNT_W'(1) - index_ff;
   assign cur_digit = digit_ff[pos[DIGIT_IDX_W-1:0]];
   assign index_nxt = index_ff + CNT_W'(1);

   always_comb begin
      unique case (phase_ff)
         PH_LIT:      cur_len = elem_is_dot(cur_digit, elem_ff) ? dot_x : dot3;
         PH_ELEM_GAP: cur_len = dot_x;
         default:     cur_len = dot3;
      endcase
   end

   // shift-and-add-three conversion, one binary bit per step
   always_comb begin
      for (int i = 0; i < MAX_DIGITS; i++) begin
         adj[i] = (digit_ff[i] >= 4'd5) ? digit_ff[i] + 4'd3 : digit_ff[i];
      end
      digit_in[0] = {adj[0][DIGIT_W-2:0], bin_ff[NUM_W-1]};
      for (int i = 1; i < MAX_DIGITS; i++) begin
         digit_in[i] = {adj[i][DIGIT_W-2:0], adj[i-1][DIGIT_W-1]};
      end
      bin_in  = {bin_ff[NUM_W-2:0], 1'b0};
      step_in = step_ff + STEP_W'(1);
   end

   // digit count: highest nonzero digit, at least one
   always_comb begin
      found_cnt = CNT_W'(1);
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (digit_ff[i] != '0) begin
            found_cnt = CNT_W'(i + 1);
         end
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      index_in    = index_ff;
      elem_in     = elem_ff;
      tick_in     = tick_ff;
      finished_in = 1'b0;
      if (cmd.start_finish) begin
         count_in = found_cnt;
         index_in = '0;
         elem_in  = '0;
         tick_in  = '0;
         phase_in = PH_LIT;
      end else if (cmd.tick_apply && phase_ff != PH_IDLE) begin
         if (tick_inc >= cur_len) begin
            tick_in = '0;
            unique case (phase_ff)
               PH_LIT: begin
                  phase_in = (elem_ff < ELEM_LAST) ? PH_ELEM_GAP : PH_DIGIT_GAP;
               end
               PH_ELEM_GAP: begin
                  elem_in  = elem_ff + ELEM_W'(1);
                  phase_in = PH_LIT;
               end
               PH_DIGIT_GAP: begin
                  index_in = index_nxt;
                  elem_in  = '0;
                  if (index_nxt >= count_ff) begin
                     phase_in    = PH_IDLE;
                     finished_in = 1'b1;
                  end else begin
                     phase_in = PH_LIT;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end else begin
            tick_in = tick_inc;
         end
      end
   end

   assign sts.phase_idle = (phase_ff == PH_IDLE);
   assign sts.conv_last  = (step_ff == STEP_W'(NUM_W - 1));
   assign sts.op_start   = (op_ff == OP_START);

   always_ff @(posedge clock) begin
      if (reset) begin
         dot_ticks_ff <= DOT_TICKS_RESET;
         active_ff    <= ACTIVE_LEVEL_RESET;
         op_ff        <= OP_TICK;
         step_ff      <= '0;
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         index_ff     <= '0;
         elem_ff      <= '0;
         tick_ff      <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_DOT_TICKS:    dot_ticks_ff <= csr_write_data;
               CSR_ACTIVE_LEVEL: active_ff    <= csr_write_data[0];
               default:          dot_ticks_ff <= dot_ticks_ff;
            endcase
         end
         if (cmd.capture) begin
            op_ff <= req_operation;
         end
         if (cmd.conv_init) begin
            step_ff <= '0;
         end else if (cmd.conv_step) begin
            step_ff <= step_in;
         end
         phase_ff <= phase_in;
         count_ff <= count_in;
         index_ff <= index_in;
         elem_ff  <= elem_in;
         tick_ff  <= tick_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.conv_init) begin
         bin_ff <= req_number;
         for (int i = 0; i < MAX_DIGITS; i++) begin
            digit_ff[i] <= '0;
         end
      end else if (cmd.conv_step) begin
         bin_ff <= bin_in;
         for (int i = 0; i < MAX_DIGITS; i++) begin
            digit_ff[i] <= digit_in[i];
         end
      end
      if (cmd.rsp_load) begin
         rsp_led_level <= (phase_in == PH_LIT) ? active_ff : !active_ff;
         rsp_busy_res  <= (phase_in != PH_IDLE);
         rsp_finished  <= finished_in;
      end
   end

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (index_ff < count_ff))
      else $error("digit index past digit count during a send");

   a_tick_below_len: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (tick_ff < cur_len))
      else $error("tick count reached phase length without advancing");

   a_elem_range: assert property (@(posedge clock) disable iff (reset)
      elem_ff <= ELEM_LAST)
      else $error("element index beyond last element");

endmodule

### sv/morse_number_led_blinker_core.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake          Payload
// req       in         req_valid/ready    req_operation, req_number
// rsp       out        rsp_valid/ready    rsp_led_level, rsp_busy_res, rsp_finished
// csr       in         csr_write_enable   csr_index, csr_write_data
//
// A tick, or a start that arrives during a send, goes from acceptance to the execute state;
// a start while idle instead runs the 31-step binary-to-decimal conversion (one bit per
// cycle) and then the finish state. Both loading states wait for a free response register.
// Reset is synchronous: no send in progress, dot length 100, lit level 1.
// The response register holds its request's result until taken; the next request is
// accepted meanwhile, and its result waits until the register frees.

module morse_number_led_blinker_core import mnlb_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_operation,
   input  logic [NUM_W-1:0] req_number,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_led_level,
   output logic             rsp_busy_res,
   output logic             rsp_finished,
   input  logic             csr_write_enable,
   input  logic             csr_index,
   input  logic [DOT_W-1:0] csr_write_data
);

   // controller issues one command set per cycle, datapath reports back status
   cmd_type cmd;
   sts_type sts;

   // sequencer: accept, run conversion steps, hold result until the output is free
   mnlb_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .sts           (sts),
      .cmd           (cmd),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready)
   );

   // digit store, Morse timing counters, config registers and response payload
   mnlb_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_operation    (req_operation),
      .req_number       (req_number),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_led_level    (rsp_led_level),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_finished     (rsp_finished)
   );

endmodule
